FILE: design/dryden_gust_wind_filter_unit_defines.svh
// ----------------------------------------------------------------------------
// Dryden gust wind filter: assertion macros
// Shared concurrent assertion forms, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef DRYDEN_GUST_WIND_FILTER_UNIT_DEFINES_SVH
`define DRYDEN_GUST_WIND_FILTER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define DGWF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define DGWF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DGWF_ASSERT(label, prop, msg)
`define DGWF_ASSERT_RST(label, prop, msg)
`endif
`endif

FILE: design/dgwf_pkg.sv
// ----------------------------------------------------------------------------
// Dryden gust wind filter package
// Payload types, fixed-point widths, filter coefficients and register indexes.
// ----------------------------------------------------------------------------
package dgwf_pkg;

  localparam int WIND_W  = 24;
  localparam int QUAT_W  = 16;
  localparam int NOISE_W = 16;
  localparam int GUST_W  = 32;
  localparam int ACC_W   = 64;
  // Serial operand width: holds every coefficient, quaternion part and wind value.
  localparam int B_W     = (WIND_W > 24) ? WIND_W : 24;
  localparam int CFG_IDX_W = 2;

  // Unsigned Q1.22 coefficients.
  localparam logic [22:0] C_X_FB   = 23'd4187174;
  localparam logic [22:0] C_X_IN   = 23'd26282;
  localparam logic [22:0] C_YZ_FB1 = 23'd8329888;
  localparam logic [22:0] C_YZ_FB2 = 23'd4135983;
  localparam logic [22:0] C_YZ_IN0 = 23'd42321;
  localparam logic [22:0] C_YZ_IN1 = 23'd171;
  localparam logic [22:0] C_YZ_IN2 = 23'd42153;

  localparam logic [CFG_IDX_W-1:0] CFG_WIND_NORTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIND_EAST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIND_DOWN  = 2'd2;

  typedef struct packed {
    logic                       pose_valid;
    logic signed [QUAT_W-1:0]   quat_w;
    logic signed [QUAT_W-1:0]   quat_x;
    logic signed [QUAT_W-1:0]   quat_y;
    logic signed [QUAT_W-1:0]   quat_z;
    logic signed [NOISE_W-1:0]  noise_x;
    logic signed [NOISE_W-1:0]  noise_y;
    logic signed [NOISE_W-1:0]  noise_z;
  } in_t;

  typedef struct packed {
    logic signed [WIND_W-1:0] body_wind_x;
    logic signed [WIND_W-1:0] body_wind_y;
    logic signed [WIND_W-1:0] body_wind_z;
  } out_t;

endpackage

FILE: design/dryden_gust_wind_filter_unit.sv
// ----------------------------------------------------------------------------
// Dryden gust wind filter unit
// Rotates the steady wind into the body frame and adds Dryden gusts.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, in_data) carries one tick: pose flag,
// quaternion and three noise samples. The output channel (out_valid,
// out_stall, out_data) returns exactly one body wind result per tick.
// Steady wind registers are written through cfg_we, cfg_index, cfg_data; the
// user is to write them only while the unit is idle, which the unit itself
// does not enforce. Indexes beyond the list are ignored.
// Every product goes through one shift-add multiplier that consumes one bit
// of its serial operand per cycle. A valid tick runs 40 products, each through
// S_LOAD, S_MUL and S_POST, before S_FINISH writes the result; an invalid tick
// goes straight to S_FINISH and repeats the last result. One tick is worked on
// at a time; in_stall is high while busy.
// A finished result waits in the output register while out_stall is high,
// and a new tick can be taken in that time; the unit holds before writing
// the following result until the waiting one has been transferred.
// Reset clears the filter delays, steady wind and last result to zero.
// ----------------------------------------------------------------------------
`include "dryden_gust_wind_filter_unit_defines.svh"

module dryden_gust_wind_filter_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dgwf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dgwf_pkg::WIND_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dgwf_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dgwf_pkg::out_t                      out_data
);

  localparam int ACC_W  = dgwf_pkg::ACC_W;
  localparam int B_W    = dgwf_pkg::B_W;
  localparam int WW     = dgwf_pkg::WIND_W;
  localparam int GW     = dgwf_pkg::GUST_W;
  localparam int NW     = dgwf_pkg::NOISE_W;
  localparam int QW     = dgwf_pkg::QUAT_W;
  localparam int CNT_W  = $clog2(B_W);
  localparam logic [3:0] STEP_ROT = 4'd13;
  localparam logic signed [ACC_W-1:0] ONE_Q28 = ACC_W'(64'sd268435456);
  localparam logic signed [ACC_W-1:0] WIND_HI = ACC_W'((64'sd1 <<< (WW - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] WIND_LO = -WIND_HI - ACC_W'(64'sd1);
  localparam logic signed [ACC_W-1:0] GUST_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] GUST_LO = -GUST_HI - ACC_W'(64'sd1);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MUL, S_POST, S_FINISH} state_t;

  function automatic logic signed [GW-1:0] gust_round(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = (v + ACC_W'(64'sd2097152)) >>> 22;
    if (t > GUST_HI) return GUST_HI[GW-1:0];
    else if (t < GUST_LO) return GUST_LO[GW-1:0];
    else return t[GW-1:0];
  endfunction

  function automatic logic signed [WW-1:0] wind_round(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = (v + ACC_W'(64'sd134217728)) >>> 28;
    if (t > WIND_HI) return WIND_HI[WW-1:0];
    else if (t < WIND_LO) return WIND_LO[WW-1:0];
    else return t[WW-1:0];
  endfunction

  state_t state;
  dgwf_pkg::in_t item;
  logic [3:0] step;
  logic [1:0] row, col, ph;
  logic [CNT_W-1:0] bit_cnt;
  logic signed [ACC_W-1:0] acc, bacc, a_sh;
  logic [B_W-1:0] b_sh;
  logic neg_r, to_body_r;
  logic signed [WW-1:0] wind [3];
  logic signed [WW-1:0] body [3];
  logic signed [GW-1:0] gx, gy0, gy1, gz0, gz1;
  logic signed [NW-1:0] nxp, ny0, ny1, nz0, nz1;

  // Operation decode for the current product.
  logic signed [ACC_W-1:0] a_val, acc_init, addend;
  logic [B_W-1:0] b_val;
  logic neg, to_body, clr_acc, clr_body, sub;
  logic signed [QW-1:0] qa, qb;
  logic signed [GW-1:0] g_row, g_new;
  logic [22:0] coef;

  always_comb begin
    a_val    = '0;
    coef     = '0;
    b_val    = '0;
    neg      = 1'b0;
    to_body  = 1'b0;
    clr_acc  = 1'b0;
    clr_body = 1'b0;
    acc_init = '0;
    qa       = '0;
    qb       = '0;
    unique case (step)
      4'd0:  begin a_val = ACC_W'(gx); coef = dgwf_pkg::C_X_FB; clr_acc = 1'b1; end
      4'd1:  begin a_val = ACC_W'(item.noise_x) <<< 8; coef = dgwf_pkg::C_X_IN; end
      4'd2:  begin a_val = ACC_W'(nxp) <<< 8; coef = dgwf_pkg::C_X_IN; end
      4'd3:  begin a_val = ACC_W'(gy0); coef = dgwf_pkg::C_YZ_FB1; clr_acc = 1'b1; end
      4'd4:  begin a_val = ACC_W'(gy1); coef = dgwf_pkg::C_YZ_FB2; neg = 1'b1; end
      4'd5:  begin a_val = ACC_W'(item.noise_y) <<< 8; coef = dgwf_pkg::C_YZ_IN0; end
      4'd6:  begin a_val = ACC_W'(ny0) <<< 8; coef = dgwf_pkg::C_YZ_IN1; end
      4'd7:  begin a_val = ACC_W'(ny1) <<< 8; coef = dgwf_pkg::C_YZ_IN2; neg = 1'b1; end
      4'd8:  begin a_val = ACC_W'(gz0); coef = dgwf_pkg::C_YZ_FB1; clr_acc = 1'b1; end
      4'd9:  begin a_val = ACC_W'(gz1); coef = dgwf_pkg::C_YZ_FB2; neg = 1'b1; end
      4'd10: begin a_val = ACC_W'(item.noise_z) <<< 8; coef = dgwf_pkg::C_YZ_IN0; end
      4'd11: begin a_val = ACC_W'(nz0) <<< 8; coef = dgwf_pkg::C_YZ_IN1; end
      4'd12: begin a_val = ACC_W'(nz1) <<< 8; coef = dgwf_pkg::C_YZ_IN2; neg = 1'b1; end
      default: begin
        if (ph == 2'd2) begin
          // The finished matrix entry in acc scales one steady wind component.
          a_val   = acc;
          to_body = 1'b1;
        end else begin
          clr_acc  = (ph == 2'd0);
          clr_body = (ph == 2'd0) && (col == 2'd0);
          acc_init = (row == col) ? ONE_Q28 : '0;
          // Two signed quaternion products per rotation matrix entry.
          unique case ({row, col, ph[0]})
            5'b00000: begin qa = item.quat_y; qb = item.quat_y; neg = 1'b1; end
            5'b00001: begin qa = item.quat_z; qb = item.quat_z; neg = 1'b1; end
            5'b00010: begin qa = item.quat_x; qb = item.quat_y; end
            5'b00011: begin qa = item.quat_w; qb = item.quat_z; neg = 1'b1; end
            5'b00100: begin qa = item.quat_x; qb = item.quat_z; end
            5'b00101: begin qa = item.quat_w; qb = item.quat_y; end
            5'b01000: begin qa = item.quat_x; qb = item.quat_y; end
            5'b01001: begin qa = item.quat_w; qb = item.quat_z; end
            5'b01010: begin qa = item.quat_x; qb = item.quat_x; neg = 1'b1; end
            5'b01011: begin qa = item.quat_z; qb = item.quat_z; neg = 1'b1; end
            5'b01100: begin qa = item.quat_y; qb = item.quat_z; end
            5'b01101: begin qa = item.quat_w; qb = item.quat_x; neg = 1'b1; end
            5'b10000: begin qa = item.quat_x; qb = item.quat_z; end
            5'b10001: begin qa = item.quat_w; qb = item.quat_y; neg = 1'b1; end
            5'b10010: begin qa = item.quat_y; qb = item.quat_z; end
            5'b10011: begin qa = item.quat_w; qb = item.quat_x; end
            5'b10100: begin qa = item.quat_x; qb = item.quat_x; neg = 1'b1; end
            5'b10101: begin qa = item.quat_y; qb = item.quat_y; neg = 1'b1; end
            default:  begin qa = '0; qb = '0; end
          endcase
          a_val = ACC_W'(qa) <<< 1;
        end
      end
    endcase
    if (step == STEP_ROT) begin
      if (ph == 2'd2) begin
        unique case (col)
          2'd0:    b_val = B_W'(wind[0]);
          2'd1:    b_val = B_W'(wind[1]);
          default: b_val = B_W'(wind[2]);
        endcase
      end else begin
        b_val = B_W'(qb);
      end
    end else begin
      b_val = B_W'(coef);
    end
  end

  always_comb begin
    unique case (row)
      2'd0:    g_row = gx;
      2'd1:    g_row = gy0;
      default: g_row = gz0;
    endcase
    g_new  = gust_round(acc);
    addend = b_sh[0] ? a_sh : '0;
    // The top bit of the serial operand carries negative weight.
    sub    = (bit_cnt == CNT_W'(B_W - 1)) ^ neg_r;
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
      row       <= '0;
      col       <= '0;
      ph        <= '0;
      bit_cnt   <= '0;
      gx  <= '0; gy0 <= '0; gy1 <= '0; gz0 <= '0; gz1 <= '0;
      nxp <= '0; ny0 <= '0; ny1 <= '0; nz0 <= '0; nz1 <= '0;
      for (int i = 0; i < 3; i++) begin
        wind[i] <= '0;
        body[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          dgwf_pkg::CFG_WIND_NORTH: wind[0] <= cfg_data;
          dgwf_pkg::CFG_WIND_EAST:  wind[1] <= cfg_data;
          dgwf_pkg::CFG_WIND_DOWN:  wind[2] <= cfg_data;
          default: ;
        endcase
      end
      // In S_FINISH the output register is written below instead.
      if (out_valid && !out_stall && state != S_FINISH) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            step <= '0;
            row  <= '0;
            col  <= '0;
            ph   <= '0;
            state <= in_data.pose_valid ? S_LOAD : S_FINISH;
          end
        end
        S_LOAD: begin
          a_sh      <= a_val;
          b_sh      <= b_val;
          neg_r     <= neg;
          to_body_r <= to_body;
          bit_cnt   <= '0;
          if (clr_acc) acc <= acc_init;
          if (clr_body) bacc <= ACC_W'(g_row) <<< 20;
          state <= S_MUL;
        end
        S_MUL: begin
          if (to_body_r) bacc <= sub ? bacc - addend : bacc + addend;
          else acc <= sub ? acc - addend : acc + addend;
          a_sh    <= a_sh <<< 1;
          b_sh    <= b_sh >> 1;
          bit_cnt <= bit_cnt + CNT_W'(1);
          if (bit_cnt == CNT_W'(B_W - 1)) state <= S_POST;
        end
        S_POST: begin
          state <= S_LOAD;
          if (step != STEP_ROT) begin
            if (step == 4'd2) begin
              gx  <= g_new;
              nxp <= item.noise_x;
            end
            if (step == 4'd7) begin
              gy1 <= gy0; gy0 <= g_new;
              ny1 <= ny0; ny0 <= item.noise_y;
            end
            if (step == 4'd12) begin
              gz1 <= gz0; gz0 <= g_new;
              nz1 <= nz0; nz0 <= item.noise_z;
            end
            step <= step + 4'd1;
          end else if (ph != 2'd2) begin
            ph <= ph + 2'd1;
          end else begin
            ph <= '0;
            if (col == 2'd2) begin
              body[row] <= wind_round(bacc);
              col <= '0;
              if (row == 2'd2) state <= S_FINISH;
              else row <= row + 2'd1;
            end else begin
              col <= col + 2'd1;
            end
          end
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_data.body_wind_x <= body[0];
            out_data.body_wind_y <= body[1];
            out_data.body_wind_z <= body[2];
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DGWF_ASSERT(a_hold_skips_filter,
    (state == S_IDLE && in_valid && !in_data.pose_valid) |=> state == S_FINISH,
    "invalid pose did not go straight to the result")
  `DGWF_ASSERT(a_finish_shows_result,
    (state == S_FINISH && (!out_valid || !out_stall)) |=> (out_valid && state == S_IDLE),
    "finished result was not presented")
  `DGWF_ASSERT(a_mul_count_range,
    (state == S_MUL) |-> (bit_cnt <= CNT_W'(B_W - 1) && step <= STEP_ROT),
    "multiplier sequence out of range")
  `DGWF_ASSERT_RST(a_reset_clears_output,
    rst |=> (!out_valid && state == S_IDLE),
    "reset left a result or busy state")

endmodule
